/* hdl/bed_pkg.sv */
package bed_pkg;

  // input operation codes
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_FINISH
  } bed_state_e;

  // control from the sequencer to the band unit
  typedef struct packed {
    logic init;
    logic step;
  } band_ctl_t;

  // start value of band cell j for a distance limit of k
  function automatic int bed_start_cell(input int j, input int k);
    int v;
    if (j == 0 || j == 2 * k + 2) begin
      v = k + 1;
    end else if (j <= k) begin
      v = k + 1 - j;
    end else begin
      v = j - k - 1;
    end
    return v;
  endfunction

endpackage

/* hdl/bed_pstore.sv */
module bed_pstore #(
  parameter int MAX_PATTERN_LEN = 64
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     wr_i,
  input  logic [7:0]                               symbol_i,
  input  logic                                     last_i,
  input  logic                                     empty_i,
  input  logic [((MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1)-1:0] rd_addr_i,
  output logic [7:0]                               rd_data_o,
  output logic [$clog2(MAX_PATTERN_LEN + 1)-1:0]   len_o,
  output logic                                     overflow_o
);

  localparam int AW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int LW = $clog2(MAX_PATTERN_LEN + 1);

  logic [7:0]    mem_q [MAX_PATTERN_LEN];
  logic [LW-1:0] len_q, len_d, base_len;
  logic          ovf_q, ovf_d, base_ovf;
  logic          closed_q, closed_d;
  logic          mem_we;

  // pattern bookkeeping for one pattern byte transfer
  always_comb begin
    base_len = closed_q ? '0 : len_q;
    base_ovf = closed_q ? 1'b0 : ovf_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    closed_d = closed_q;
    mem_we   = 1'b0;
    if (wr_i) begin
      if (empty_i) begin
        len_d    = '0;
        ovf_d    = 1'b0;
        closed_d = 1'b1;
      end else begin
        closed_d = last_i;
        if (base_len < LW'(MAX_PATTERN_LEN)) begin
          mem_we = 1'b1;
          len_d  = base_len + 1'b1;
          ovf_d  = base_ovf;
        end else begin
          len_d  = base_len;
          ovf_d  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      ovf_q    <= 1'b0;
      closed_q <= 1'b1;
    end else begin
      len_q    <= len_d;
      ovf_q    <= ovf_d;
      closed_q <= closed_d;
    end
  end

  // pattern memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[base_len[AW-1:0]] <= symbol_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

  assign len_o      = len_q;
  assign overflow_o = ovf_q;

endmodule

/* hdl/bed_band.sv */
module bed_band #(
  parameter int MAX_DIST = 2
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  bed_pkg::band_ctl_t                     ctl_i,
  input  logic                                   cost_i,
  input  logic [$clog2(2 * MAX_DIST + 3)-1:0]    rd_idx_i,
  output logic [$clog2(MAX_DIST + 2)-1:0]        rd_cell_o,
  output logic                                   row_done_o
);

  import bed_pkg::*;

  localparam int BAND_LEN = 2 * MAX_DIST + 3;
  localparam int LAST     = BAND_LEN - 1;
  localparam int IW       = $clog2(BAND_LEN);
  localparam int CELL_W   = $clog2(MAX_DIST + 2);
  localparam int SW       = CELL_W + 1;
  localparam logic [SW-1:0]     OVER_S = SW'(MAX_DIST + 1);
  localparam logic [CELL_W-1:0] LIMIT  = CELL_W'(MAX_DIST);

  logic [CELL_W-1:0] ring_q [BAND_LEN];
  logic [CELL_W-1:0] left_q;
  logic [IW-1:0]     pos_q, low_q, high_q, lo_new_q, last_good_q;
  logic              scan_q, any_good_q;

  logic [SW-1:0]     diag, left1, up1, m0, m1;
  logic [CELL_W-1:0] cell_new;
  logic              in_range, good;

  // shared cell unit: min of left, up and diagonal, clamped at one above the limit
  always_comb begin
    diag     = {1'b0, ring_q[0]} + SW'(cost_i);
    left1    = {1'b0, left_q} + SW'(1);
    up1      = {1'b0, ring_q[1]} + SW'(1);
    m0       = (left1 < up1) ? left1 : up1;
    m1       = (diag < m0) ? diag : m0;
    if (m1 > OVER_S) begin
      m1 = OVER_S;
    end
    in_range = (pos_q >= low_q) && (pos_q < high_q);
    cell_new = in_range ? m1[CELL_W-1:0] : ring_q[0];
    good     = (cell_new <= LIMIT);
  end

  // ring of band cells, cell at the head position is the one in work
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < BAND_LEN; j++) begin
        ring_q[j] <= CELL_W'(bed_start_cell(j, MAX_DIST));
      end
      left_q <= '0;
    end else if (ctl_i.init) begin
      for (int j = 0; j < BAND_LEN; j++) begin
        ring_q[j] <= CELL_W'(bed_start_cell(j, MAX_DIST));
      end
    end else if (ctl_i.step) begin
      for (int j = 0; j < LAST; j++) begin
        ring_q[j] <= ring_q[j+1];
      end
      ring_q[LAST] <= cell_new;
      left_q       <= cell_new;
    end
  end

  // position counter and edge tracking across one pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      low_q       <= IW'(1);
      high_q      <= IW'(LAST);
      lo_new_q    <= '0;
      last_good_q <= '0;
      scan_q      <= 1'b0;
      any_good_q  <= 1'b0;
    end else if (ctl_i.init) begin
      pos_q  <= '0;
      low_q  <= IW'(1);
      high_q <= IW'(LAST);
    end else if (ctl_i.step) begin
      if (pos_q == IW'(LAST)) begin
        pos_q  <= '0;
        low_q  <= lo_new_q;
        high_q <= any_good_q ? (last_good_q + IW'(1)) : lo_new_q;
      end else begin
        pos_q <= pos_q + IW'(1);
      end
      if (pos_q == '0) begin
        scan_q     <= 1'b1;
        lo_new_q   <= low_q;
        any_good_q <= 1'b0;
      end else if (in_range) begin
        if (scan_q) begin
          if (good) begin
            scan_q <= 1'b0;
          end else begin
            lo_new_q <= pos_q + IW'(1);
          end
        end
        if (good) begin
          any_good_q  <= 1'b1;
          last_good_q <= pos_q;
        end
      end
    end
  end

  assign rd_cell_o  = ring_q[rd_idx_i];
  assign row_done_o = ctl_i.step && (pos_q == IW'(LAST));

endmodule

/* hdl/banded_edit_distance.sv */
// text byte: ready held low while the band pass runs, one band
//   cell a cycle through the shared cell unit, the memory read issued one cell ahead
// last text byte: result shown in the same cycle as ready returns, after the band pass
// empty text byte: result goes via the finish state to the output register; pattern byte:
//   ready stays high; a stalled result holds the input off until the output register is free
// reset: asynchronous, active low; clears all but pattern memory, column, byte, result data
module banded_edit_distance #(
  parameter int MAX_DIST        = 2,
  parameter int MAX_PATTERN_LEN = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] symbol_i,
  input  logic       last_i,
  input  logic       empty_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] distance_o,
  output logic       over_limit_o
);

  import bed_pkg::*;

  localparam int BAND_LEN = 2 * MAX_DIST + 3;
  localparam int IW       = $clog2(BAND_LEN);
  localparam int CELL_W   = $clog2(MAX_DIST + 2);
  localparam int AW       = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int LW       = $clog2(MAX_PATTERN_LEN + 1);
  localparam int ROW_CAP  = MAX_PATTERN_LEN + MAX_DIST + 2;
  localparam int RW       = $clog2(ROW_CAP + 1);
  localparam int CW       = RW + 2;
  localparam logic signed [CW-1:0] COL_OFS = CW'(MAX_DIST + 2);
  localparam logic signed [CW-1:0] LIM     = CW'(MAX_DIST + 1);
  localparam logic [CELL_W-1:0]    OVER    = CELL_W'(MAX_DIST + 1);
  localparam logic [CELL_W-1:0]    LIMIT   = CELL_W'(MAX_DIST);

  bed_state_e state_q, state_d;
  band_ctl_t  ctl;

  logic [RW-1:0]          rows_q, rows_d, rows_inc;
  logic signed [CW-1:0]   col_q, col_d, col0, rd_col, diff, idx_sum;
  logic                   col_ok_q, col_ok_d;
  logic [7:0]             sym_q;
  logic                   last_q;
  logic                   in_xfer, pat_wr, text_xfer;
  logic [AW-1:0]          rd_addr;
  logic [7:0]             rd_data;
  logic [LW-1:0]          len;
  logic                   overflow;
  logic                   cost;
  logic [IW-1:0]          rd_idx;
  logic [CELL_W-1:0]      rd_cell, res_dist;
  logic                   in_band, row_done, load_out;
  logic                   out_valid_q;
  logic [1:0]             distance_q;
  logic                   over_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign pat_wr     = in_xfer && (op_i == OP_PATTERN);
  assign text_xfer  = in_xfer && (op_i == OP_TEXT);

  // row count and first column of the pass
  always_comb begin
    rows_inc = (rows_q < RW'(ROW_CAP)) ? (rows_q + RW'(1)) : rows_q;
    col0     = $signed(CW'(rows_inc)) - COL_OFS;
    rd_col   = (state_q == ST_IDLE) ? col0 : col_q;
    col_ok_d = !rd_col[CW-1] && (rd_col[CW-2:0] < (CW-1)'(len));
    rd_addr  = rd_col[AW-1:0];
    col_d    = rd_col + CW'(1);
  end

  // substitution cost from the registered pattern byte read
  assign cost = !(col_ok_q && (rd_data == sym_q));

  // result cell on the length-difference diagonal
  always_comb begin
    diff     = $signed(CW'(len)) - $signed(CW'(rows_q));
    in_band  = (diff >= -LIM) && (diff <= LIM);
    idx_sum  = diff + LIM;
    rd_idx   = idx_sum[IW-1:0];
    res_dist = (overflow || !in_band) ? OVER : rd_cell;
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    ctl      = '0;
    rows_d   = rows_q;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (text_xfer) begin
          if (empty_req_i) begin
            ctl.init = 1'b1;
            rows_d   = '0;
            state_d  = ST_FINISH;
          end else begin
            rows_d  = rows_inc;
            state_d = ST_ROW;
          end
        end
      end
      ST_ROW: begin
        ctl.step = 1'b1;
        if (row_done) begin
          state_d = last_q ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          ctl.init = 1'b1;
          rows_d   = '0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rows_q  <= '0;
    end else begin
      state_q <= state_d;
      rows_q  <= rows_d;
    end
  end

  // column walk and text byte capture
  always_ff @(posedge clk_i) begin
    col_q    <= col_d;
    col_ok_q <= col_ok_d;
    if (text_xfer) begin
      sym_q  <= symbol_i;
      last_q <= last_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      distance_q <= res_dist[1:0];
      over_q     <= (res_dist > LIMIT);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign distance_o   = distance_q;
  assign over_limit_o = over_q;

  bed_pstore #(
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
  ) u_pstore (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (pat_wr),
    .symbol_i  (symbol_i),
    .last_i    (last_i),
    .empty_i   (empty_req_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .len_o     (len),
    .overflow_o(overflow)
  );

  bed_band #(
    .MAX_DIST(MAX_DIST)
  ) u_band (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .cost_i    (cost),
    .rd_idx_i  (rd_idx),
    .rd_cell_o (rd_cell),
    .row_done_o(row_done)
  );

endmodule

/* hdl/bed_checker.sv */
module bed_checker #(
  parameter int MAX_DIST = 2
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       op_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] distance_o,
  input logic       over_limit_o
);

  import bed_pkg::*;

  // a stalled result stays and holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o)
      && $stable(over_limit_o))
    else $error("result dropped or changed while stalled");

  // an over-limit result carries the saturated distance
  a_over_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && over_limit_o |-> distance_o == 2'(MAX_DIST + 1))
    else $error("over-limit result with wrong distance");

  // a pattern byte transfer never raises a result
  a_pat_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == OP_PATTERN |=> !$rose(out_valid_o))
    else $error("result raised by a pattern byte");

  // a text byte holds ready low in the next cycle
  a_text_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == OP_TEXT |=> !in_ready_o)
    else $error("ready straight after a text byte transfer");

endmodule

bind banded_edit_distance bed_checker #(
  .MAX_DIST(MAX_DIST)
) u_bed_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .op_i        (op_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .distance_o  (distance_o),
  .over_limit_o(over_limit_o)
);

/* tb/sv/testbench.sv */
module testbench;
  import bed_pkg::*;

  localparam int K        = 2;
  localparam int PLEN     = 64;
  localparam int BAND     = 2 * K + 3;
  localparam int OVER     = K + 1;
  localparam int ROW_CAP  = PLEN + K + 2;
  localparam int RAND_ITEMS = 740;

  typedef struct {
    logic [1:0] dval;
    logic       over;
  } dist_result_t;

  typedef struct {
    logic       op;
    logic [7:0] sym;
    logic       last;
    logic       empty;
    int         reps;
    int         want;
  } stim_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       op_i        = OP_PATTERN;
  logic [7:0] symbol_i    = 8'h00;
  logic       last_i      = 1'b0;
  logic       empty_req_i = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] distance_o;
  logic       over_limit_o;

  banded_edit_distance #(
    .MAX_DIST       (K),
    .MAX_PATTERN_LEN(PLEN)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .symbol_i    (symbol_i),
    .last_i      (last_i),
    .empty_req_i (empty_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .distance_o  (distance_o),
    .over_limit_o(over_limit_o)
  );

  // predictor state: pattern store and distance band
  logic [7:0] pat_mem [PLEN];
  int         pat_len;
  bit         pat_ovf;
  bit         pat_closed;
  int         band_val [BAND];
  int         lo_edge;
  int         hi_edge;
  int         rows;

  dist_result_t distance_q [$];
  dist_result_t head;
  stim_row_t    plan [$];
  logic [7:0]   word_q [$];
  logic [7:0]   text_q [$];
  logic [7:0]   alpha_base;

  int error_count    = 0;
  int items_sent     = 0;
  int directed_items = 0;
  int burst_left     = 0;
  int results_seen   = 0;
  int over_results   = 0;
  int dropped_bytes  = 0;
  int empty_texts    = 0;
  int stall_mode     = 0;
  int stall_left     = 0;

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // overall time limit
  initial begin
    #600000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // band back to its starting diagonal distances
  function automatic void band_restart();
    for (int j = 0; j < BAND; j++) begin
      if (j == 0 || j == BAND - 1) begin
        band_val[j] = OVER;
      end else if (j <= K) begin
        band_val[j] = OVER - j;
      end else begin
        band_val[j] = j - K - 1;
      end
    end
    lo_edge = 1;
    hi_edge = BAND - 1;
    rows    = 0;
  endfunction

  // one text row, cells updated low to high in place
  function automatic void band_advance(input logic [7:0] sym);
    int left, up, col, cost, diag, m;
    if (lo_edge >= hi_edge) return;
    for (int i = lo_edge; i < hi_edge; i++) begin
      left = band_val[i-1] + 1;
      up   = band_val[i+1] + 1;
      col  = i - K + rows - 2;
      cost = 1;
      if (col >= 0 && col < pat_len && col < PLEN) cost = (pat_mem[col] != sym) ? 1 : 0;
      diag = band_val[i] + cost;
      m = (left < up) ? left : up;
      if (diag < m) m = diag;
      if (m > OVER) m = OVER;
      band_val[i] = m;
    end
    while (lo_edge < hi_edge && band_val[lo_edge] > K) lo_edge++;
    while (hi_edge > lo_edge && band_val[hi_edge-1] > K) hi_edge--;
  endfunction

  // distance read on the length-difference diagonal
  function automatic int band_distance();
    int idx;
    if (pat_ovf) return OVER;
    idx = K + 1 + pat_len - rows;
    if (idx < 0 || idx > BAND - 1) return OVER;
    return (band_val[idx] > OVER) ? OVER : band_val[idx];
  endfunction

  // apply one transfer; returns 1 when it produces a distance
  function automatic bit edit_step(input logic op, input logic [7:0] sym, input logic last,
                                   input logic empty, output int dval);
    dval = 0;
    if (op == OP_PATTERN) begin
      if (empty) begin
        pat_len    = 0;
        pat_ovf    = 1'b0;
        pat_closed = 1'b1;
        return 1'b0;
      end
      if (pat_closed) begin
        pat_len    = 0;
        pat_ovf    = 1'b0;
        pat_closed = 1'b0;
      end
      if (pat_len < PLEN) begin
        pat_mem[pat_len] = sym;
        pat_len++;
      end else begin
        pat_ovf = 1'b1;
        dropped_bytes++;
      end
      if (last) pat_closed = 1'b1;
      return 1'b0;
    end
    if (empty) begin
      band_restart();
      dval = band_distance();
      band_restart();
      empty_texts++;
      return 1'b1;
    end
    if (rows < ROW_CAP) rows++;
    band_advance(sym);
    if (last) begin
      dval = band_distance();
      band_restart();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // drive one transfer in bursts; want >= 0 overrides the predicted distance
  task automatic push_item(input logic op, input logic [7:0] sym, input logic last,
                           input logic empty, input int want);
    int           dval;
    bit           gives;
    dist_result_t r;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    symbol_i    <= sym;
    last_i      <= last;
    empty_req_i <= empty;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    items_sent++;
    gives = edit_step(op, sym, last, empty, dval);
    if (gives) begin
      if (want >= 0) dval = want;
      r.dval = dval[1:0];
      r.over = (dval > K);
      distance_q.insert(distance_q.size(), r);
    end
  endtask

  // hold off until every outstanding distance has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (distance_q.size() != 0) @(posedge clk_i);
    repeat (2 * K + 8) @(posedge clk_i);
  endtask

  task automatic send_string(input logic op, input logic [7:0] s [$]);
    if (s.size() == 0) begin
      push_item(op, 8'($urandom), 1'($urandom_range(0, 1)), 1'b1, -1);
    end else begin
      foreach (s[i]) push_item(op, s[i], (i == s.size() - 1), 1'b0, -1);
    end
  endtask

  // append one directed row to the plan
  function automatic void add_row(input logic op, input logic [7:0] sym, input logic last,
                                  input logic empty, input int reps, input int want);
    stim_row_t row;
    row.op    = op;
    row.sym   = sym;
    row.last  = last;
    row.empty = empty;
    row.reps  = reps;
    row.want  = want;
    plan.insert(plan.size(), row);
  endfunction

  function automatic logic [7:0] alpha_sym();
    return alpha_base + 8'($urandom_range(0, 3));
  endfunction

  // new pattern over a four-letter alphabet at a random base
  task automatic make_pattern();
    int len;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) len = 0;
    else if (pick < 10) len = $urandom_range(60, 70);
    else len = $urandom_range(1, 10);
    alpha_base = 8'($urandom_range(0, 252));
    word_q.delete();
    for (int i = 0; i < len; i++) word_q.insert(word_q.size(), alpha_sym());
  endtask

  // text near the pattern: a few substitutions, insertions and deletions
  task automatic make_text();
    int n;
    int kind;
    int pos;
    text_q = word_q;
    n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 6);
    for (int e = 0; e < n; e++) begin
      kind = $urandom_range(0, 2);
      if (text_q.size() == 0) kind = 1;
      if (kind == 0) begin
        pos = $urandom_range(0, text_q.size() - 1);
        text_q[pos] = alpha_sym();
      end else if (kind == 1) begin
        pos = $urandom_range(0, text_q.size());
        text_q.insert(pos, alpha_sym());
      end else begin
        pos = $urandom_range(0, text_q.size() - 1);
        text_q.delete(pos);
      end
    end
  endtask

  // receiver stall pattern: free-running, random, or mostly stalled phases
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // compare each result transfer with the oldest expected distance
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (distance_q.size() == 0) begin
        report_mismatch("distance with nothing expected", distance_o, -1);
      end else begin
        head = distance_q.pop_front();
        results_seen++;
        if (head.over) over_results++;
        if (distance_o !== head.dval) report_mismatch("distance", distance_o, head.dval);
        if (over_limit_o !== head.over) report_mismatch("over_limit", over_limit_o, head.over);
      end
    end
  end

  initial begin : main_seq
    int pick;
    int n;
    pat_len    = 0;
    pat_ovf    = 1'b0;
    pat_closed = 1'b1;
    band_restart();

    // directed rows: op, symbol, last, empty, repeats, typed distance (-1 = predicted)
    add_row(OP_TEXT,    8'h00, 1'b1, 1'b1, 1,  0);  // empty text after reset
    add_row(OP_TEXT,    8'hA5, 1'b1, 1'b0, 1, -1);  // one byte against empty pattern
    add_row(OP_PATTERN, 8'h41, 1'b0, 1'b0, 1, -1);
    add_row(OP_PATTERN, 8'h42, 1'b1, 1'b0, 1, -1);
    add_row(OP_TEXT,    8'h41, 1'b0, 1'b0, 1, -1);
    add_row(OP_TEXT,    8'h42, 1'b1, 1'b0, 1,  0);  // exact match
    add_row(OP_TEXT,    8'h00, 1'b0, 1'b1, 1,  2);  // empty text gives pattern length
    add_row(OP_TEXT,    8'h00, 1'b0, 1'b0, 1, -1);
    add_row(OP_TEXT,    8'hFF, 1'b1, 1'b0, 1, -1);  // two substitutions
    add_row(OP_PATTERN, 8'hFF, 1'b0, 1'b1, 1, -1);  // empty pattern
    add_row(OP_TEXT,    8'h41, 1'b1, 1'b0, 6,  3);  // length gap, band collapses
    add_row(OP_PATTERN, 8'h00, 1'b0, 1'b0, 1, -1);  // open pattern
    add_row(OP_PATTERN, 8'hFF, 1'b0, 1'b0, 1, -1);
    add_row(OP_TEXT,    8'h00, 1'b0, 1'b0, 1, -1);
    add_row(OP_PATTERN, 8'h80, 1'b1, 1'b0, 1, -1);  // pattern grows mid-text
    add_row(OP_TEXT,    8'hFF, 1'b0, 1'b0, 1, -1);
    add_row(OP_TEXT,    8'h80, 1'b1, 1'b0, 1, -1);
    add_row(OP_TEXT,    8'h7F, 1'b1, 1'b0, 5, -1);  // all mismatches, saturating cells
    add_row(OP_PATTERN, 8'h55, 1'b1, 1'b0, 66, -1); // overlong pattern
    add_row(OP_TEXT,    8'h55, 1'b1, 1'b0, 64, 3);  // overflow forces over limit
    add_row(OP_TEXT,    8'h00, 1'b1, 1'b1, 1,  3);
    add_row(OP_PATTERN, 8'h00, 1'b1, 1'b1, 1, -1);  // empty pattern clears overflow
    add_row(OP_TEXT,    8'hFF, 1'b1, 1'b1, 1,  0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (plan[i]) begin
      for (int r = 0; r < plan[i].reps; r++) begin
        push_item(plan[i].op, plan[i].sym, plan[i].last && (r == plan[i].reps - 1),
                  plan[i].empty, (r == plan[i].reps - 1) ? plan[i].want : -1);
      end
    end
    directed_items = items_sent;
    drain_results();

    // random part: mostly pattern then texts, with noise and interrupted texts
    while (items_sent < directed_items + RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        drain_results();
      end else if (pick < 78) begin
        make_pattern();
        send_string(OP_PATTERN, word_q);
        n = $urandom_range(1, 3);
        for (int t = 0; t < n; t++) begin
          make_text();
          send_string(OP_TEXT, text_q);
        end
      end else if (pick < 90) begin
        n = $urandom_range(1, 8);
        for (int t = 0; t < n; t++) begin
          push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    ($urandom_range(0, 3) == 0), ($urandom_range(0, 9) == 0), -1);
        end
      end else begin
        make_text();
        n = $urandom_range(1, 4);
        for (int t = 0; t < n; t++) push_item(OP_TEXT, alpha_sym(), 1'b0, 1'b0, -1);
        n = $urandom_range(1, 3);
        for (int t = 0; t < n; t++) begin
          push_item(OP_PATTERN, alpha_sym(), ($urandom_range(0, 2) == 0), 1'b0, -1);
        end
        n = $urandom_range(1, 4);
        for (int t = 0; t < n; t++) push_item(OP_TEXT, alpha_sym(), (t == n - 1), 1'b0, -1);
      end
    end

    drain_results();
    $display("covered %0d transfers in (%0d directed), %0d distances checked",
             items_sent, directed_items, results_seen);
    $display("%0d over-limit distances, %0d empty texts, %0d dropped pattern bytes",
             over_results, empty_texts, dropped_bytes);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
